[src/stiw_pkg.sv]
// ============================================================================
// stiw_pkg
// shared types and codes for the smbios structure table type index walker
// ============================================================================
package stiw_pkg;

   // request operation codes (req_tuser)
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // command kinds handed from front to back
   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_RECORD = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // structure header size in bytes
   localparam logic [7:0] HDR_SIZE = 8'd4;

   // index table geometry
   localparam int TYPE_COUNT = 256;
   localparam int ENTRY_W    = 32;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // classified command, one per accepted request
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  type_sel;   // structure type or queried type
      logic [15:0] offset;     // start offset of counted structure
      logic        stopped;    // walk stop flag after this request
   } cmd_type;

endpackage

[src/stiw_ram.sv]
// ============================================================================
// stiw_ram
// generic single write, single read ram with registered read data
// ============================================================================
module stiw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/stiw_front.sv]
// ============================================================================
// stiw_front
// request intake and byte-level structure table parser
// ============================================================================
module stiw_front #(
   parameter int TABLE_ADDR_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          in_op,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   input  logic [7:0]          in_qtype,
   output logic                push_valid,
   input  logic                push_ready,
   output stiw_pkg::cmd_type   push_cmd
);

   localparam int OFF_W = TABLE_ADDR_BITS + 1;

   localparam logic [1:0] PH_HEADER    = 2'd0;
   localparam logic [1:0] PH_FORMATTED = 2'd1;
   localparam logic [1:0] PH_STRINGS   = 2'd2;

   logic [7:0]       end_type_ff, end_type_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       pos_ff, pos_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       stype_ff, stype_in;
   logic             prev_zero_ff, prev_zero_in;
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [15:0]      start_ff, start_in;
   logic             stopped_ff, stopped_in;

   logic fire;
   logic rec;
   logic halt;
   logic byte_zero;

   assign in_ready  = push_ready;
   assign fire      = in_valid && push_ready;
   assign byte_zero = (in_byte == 8'd0);

   always_comb begin
      end_type_in  = csr_wr_en ? csr_wr_data : end_type_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      stype_in     = stype_ff;
      prev_zero_in = prev_zero_ff;
      offset_in    = offset_ff;
      start_in     = start_ff;
      stopped_in   = stopped_ff;
      rec          = 1'b0;
      halt         = 1'b0;

      if (fire) begin
         case (in_op)
            stiw_pkg::OP_BYTE: begin
               if (!stopped_ff) begin
                  if (offset_ff[OFF_W-1]) begin
                     // table ran past capacity
                     stopped_in = 1'b1;
                  end else begin
                     case (phase_ff)
                        PH_HEADER: begin
                           if (pos_ff == 8'd0) begin
                              stype_in = in_byte;
                              start_in = 16'(offset_ff);
                           end else if (pos_ff == 8'd1) begin
                              len_in = in_byte;
                           end
                           if (pos_ff < stiw_pkg::HDR_SIZE) begin
                              pos_in = pos_ff + 8'd1;
                           end else if (stype_ff == end_type_ff ||
                                        len_ff < stiw_pkg::HDR_SIZE) begin
                              halt = 1'b1;
                           end else begin
                              rec = 1'b1;
                              if (len_ff == stiw_pkg::HDR_SIZE) begin
                                 phase_in     = PH_STRINGS;
                                 prev_zero_in = byte_zero;
                              end else begin
                                 phase_in = PH_FORMATTED;
                                 pos_in   = pos_ff + 8'd1;
                              end
                           end
                        end
                        PH_FORMATTED: begin
                           if (pos_ff >= len_ff) begin
                              phase_in     = PH_STRINGS;
                              prev_zero_in = byte_zero;
                           end else begin
                              pos_in = pos_ff + 8'd1;
                           end
                        end
                        PH_STRINGS: begin
                           if (byte_zero && prev_zero_ff) begin
                              phase_in     = PH_HEADER;
                              pos_in       = 8'd0;
                              prev_zero_in = 1'b0;
                           end else begin
                              prev_zero_in = byte_zero;
                           end
                        end
                        default: begin
                           phase_in = PH_HEADER;
                        end
                     endcase
                     if (!halt) begin
                        offset_in = offset_ff + OFF_W'(1);
                     end
                     stopped_in = halt || in_last;
                  end
               end
            end
            stiw_pkg::OP_CLEAR: begin
               phase_in     = PH_HEADER;
               pos_in       = 8'd0;
               len_in       = 8'd0;
               stype_in     = 8'd0;
               prev_zero_in = 1'b0;
               offset_in    = '0;
               start_in     = 16'd0;
               stopped_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      push_valid       = fire;
      push_cmd.stopped = stopped_in;
      push_cmd.offset  = start_ff;
      push_cmd.type_sel = in_qtype;
      if (rec) begin
         push_cmd.kind     = stiw_pkg::CMD_RECORD;
         push_cmd.type_sel = stype_ff;
      end else if (in_op == stiw_pkg::OP_QUERY) begin
         push_cmd.kind = stiw_pkg::CMD_QUERY;
      end else if (in_op == stiw_pkg::OP_CLEAR) begin
         push_cmd.kind = stiw_pkg::CMD_CLEAR;
      end else begin
         push_cmd.kind = stiw_pkg::CMD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_type_ff  <= 8'd127;
         phase_ff     <= PH_HEADER;
         pos_ff       <= 8'd0;
         len_ff       <= 8'd0;
         stype_ff     <= 8'd0;
         prev_zero_ff <= 1'b0;
         offset_ff    <= '0;
         start_ff     <= 16'd0;
         stopped_ff   <= 1'b0;
      end else begin
         end_type_ff  <= end_type_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         stype_ff     <= stype_in;
         prev_zero_ff <= prev_zero_in;
         offset_ff    <= offset_in;
         start_ff     <= start_in;
         stopped_ff   <= stopped_in;
      end
   end

endmodule

[src/stiw_queue.sv]
// ============================================================================
// stiw_queue
// two-entry command queue between front and back
// ============================================================================
module stiw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  stiw_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output stiw_pkg::cmd_type pop_cmd
);

   stiw_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/stiw_back.sv]
// ============================================================================
// stiw_back
// type index table update and lookup, with result register
// ============================================================================
module stiw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  stiw_pkg::cmd_type cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata
);

   localparam int AW = $clog2(stiw_pkg::TYPE_COUNT);

   // lookup stage
   logic                            lk_valid_ff;
   stiw_pkg::cmd_type               lk_cmd_ff;
   logic                            lk_entry_ok_ff;
   logic                            lk_byp_hit_ff;
   logic [stiw_pkg::ENTRY_W-1:0]    lk_byp_data_ff;

   // entry valid bits, an invalid entry reads as zero
   logic [stiw_pkg::TYPE_COUNT-1:0] entry_ok_ff, entry_ok_in;

   // result register
   logic        out_valid_ff;
   logic [63:0] out_data_ff, out_data_in;

   logic                         out_free, lk_adv, lk_free, issue;
   logic [stiw_pkg::ENTRY_W-1:0] ram_q, entry, wr_entry;
   logic [15:0]                  cnt, first, cnt_next, first_next;
   logic                         wr_en;
   logic [15:0]                  q_first, q_count;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign lk_adv    = lk_valid_ff && out_free;
   assign lk_free   = !lk_valid_ff || lk_adv;
   assign issue     = cmd_valid && lk_free;
   assign cmd_ready = lk_free;

   stiw_ram #(
      .WIDTH (stiw_pkg::ENTRY_W),
      .DEPTH (stiw_pkg::TYPE_COUNT)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lk_cmd_ff.type_sel),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (cmd.type_sel),
      .rd_data (ram_q)
   );

   always_comb begin
      if (lk_byp_hit_ff) begin
         entry = lk_byp_data_ff;
      end else if (lk_entry_ok_ff) begin
         entry = ram_q;
      end else begin
         entry = '0;
      end
      cnt        = entry[31:16];
      first      = entry[15:0];
      cnt_next   = (cnt == stiw_pkg::COUNT_MAX) ? cnt : cnt + 16'd1;
      first_next = (cnt == 16'd0) ? lk_cmd_ff.offset : first;
      wr_entry   = {cnt_next, first_next};
      wr_en      = lk_adv && (lk_cmd_ff.kind == stiw_pkg::CMD_RECORD);
   end

   // clear issued behind an in-flight write still wins
   always_comb begin
      entry_ok_in = entry_ok_ff;
      if (wr_en) begin
         entry_ok_in[lk_cmd_ff.type_sel] = 1'b1;
      end
      if (issue && cmd.kind == stiw_pkg::CMD_CLEAR) begin
         entry_ok_in = '0;
      end
   end

   always_comb begin
      q_first = 16'd0;
      q_count = 16'd0;
      if (lk_cmd_ff.kind == stiw_pkg::CMD_QUERY) begin
         q_first = first;
         q_count = cnt;
      end
      out_data_in = {6'd0, lk_cmd_ff.stopped, q_count, q_first, 25'd0};
      if (lk_cmd_ff.kind == stiw_pkg::CMD_RECORD) begin
         out_data_in[24:0] = {lk_cmd_ff.offset, lk_cmd_ff.type_sel, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         lk_cmd_ff      <= cmd;
         lk_entry_ok_ff <= entry_ok_ff[AW'(cmd.type_sel)];
         lk_byp_hit_ff  <= wr_en && (lk_cmd_ff.type_sel == cmd.type_sel);
         lk_byp_data_ff <= wr_entry;
      end
      if (lk_adv) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         entry_ok_ff  <= '0;
      end else begin
         lk_valid_ff  <= issue || (lk_valid_ff && !lk_adv);
         out_valid_ff <= lk_adv || (out_valid_ff && !rsp_tready);
         entry_ok_ff  <= entry_ok_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[src/smbios_type_index_walker_core.sv]
// ============================================================================
// smbios_type_index_walker_core
// smbios structure table walker with a per-type first offset and count index
// ============================================================================
// The block takes one request per cycle when not stalled and returns exactly
// one response per request, in order. A request passes the queue slot, then
// the index ram lookup stage, then the result register before rsp_tvalid
// rises. A table byte request advances the header/formatted/string parser;
// when the fifth byte of a structure arrives and the structure is valid, its
// type gets its first offset recorded (if new) and its count bumped, saturating
// at 65535. The walk stops on the end marker type, a formatted length below
// 4, the last byte, or a byte beyond 2^TABLE_ADDR_BITS; only a clear request
// restarts it. A query request returns one type's entry. A clear empties the
// index at once through per-entry valid bits, with no sweep. Throughput is
// one request per cycle when not stalled: the front parser does one byte per
// cycle, and the back end reads the 256-entry index ram once and writes it at
// most once per request, forwarding a fresh write to the next read. csr_wr_data
// sets the end marker type (reset 127); the user must write it only while the
// block is idle, and the block does not enforce this.
// ============================================================================
module smbios_type_index_walker_core #(
   parameter int TABLE_ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // end_marker_type
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [7:0] data_byte, [15:8] query_type
   input  logic [1:0]  req_tuser,     // [1:0] operation
   input  logic        req_tlast,     // last_byte
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata      // [0] recorded, [8:1] rec_type,
                                      // [24:9] rec_offset, [40:25] query_first,
                                      // [56:41] query_count, [57] walk_stopped
);

   // front to queue
   logic              push_valid;
   logic              push_ready;
   stiw_pkg::cmd_type push_cmd;

   // queue to back
   logic              pop_valid;
   logic              pop_ready;
   stiw_pkg::cmd_type pop_cmd;

   // parser: classifies each transfer and tracks walk state
   stiw_front #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_op       (req_tuser),
      .in_byte     (req_tdata[7:0]),
      .in_last     (req_tlast),
      .in_qtype    (req_tdata[15:8]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   // short queue so front and back stall independently
   stiw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // index table read-modify-write and response register
   stiw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_ready  (pop_ready),
      .cmd        (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a type with no structures counted has no first offset
   a_count_zero_first_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[56:41] == 16'd0) |-> (rsp_tdata[40:25] == 16'd0)
   ) else $error("query returned a first offset with a zero count");

   // a recorded structure never carries query data
   a_record_no_query: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[56:25] == 32'd0)
   ) else $error("record response carries query fields");

   // record fields stay zero unless a structure was counted
   a_norecord_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[24:1] == 24'd0)
   ) else $error("record fields set without a counted structure");

   // a query popped from the queue always enters the lookup stage
   a_queue_flow: assert property (
      @(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && pop_cmd.kind == stiw_pkg::CMD_QUERY)
         |=> (u_back.lk_valid_ff)
   ) else $error("query lost between queue and lookup stage");

endmodule

[test/tb_smbios_type_index_walker_core.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_smbios_type_index_walker_core
// self-checking bench for the smbios structure table type index walker
// ============================================================================
// A driver feeds requests from a pending queue and a monitor takes responses,
// both with random per-transfer idle cycles. Every accepted request runs
// through a predictor of the walker (header, formatted area and string scan,
// per-type first offset and count), and each response is compared field by
// field with the oldest prediction. The run covers directed corner cases,
// random tables under several end marker settings, one full-rate setting and
// a long receiver stall.
// ============================================================================
module tb_smbios_type_index_walker_core;

   localparam int          ADDR_BITS     = 16;
   localparam int unsigned WALK_CAPACITY = 1 << ADDR_BITS;
   localparam logic [1:0]  OP_NOP        = 2'd3;   // unused operation code
   localparam int          RUN_ITEMS     = 450;    // random requests per setting
   localparam int          HOLD_AT       = 400;    // response count for the long stall
   localparam int          HOLD_CYCLES   = 300;
   localparam int          REPORT_CAP    = 200;

   typedef enum logic [1:0] {WALK_HEADER, WALK_FORMATTED, WALK_STRINGS} walk_phase_type;

   typedef struct {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       is_last;
      logic [7:0] query_type;
   } walk_req_type;

   typedef struct {
      logic        recorded;
      logic [7:0]  rec_type;
      logic [15:0] rec_offset;
      logic [15:0] query_first;
      logic [15:0] query_count;
      logic        walk_stopped;
   } walk_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;   // [7:0] data_byte, [15:8] query_type
   logic [1:0]  req_tuser = 2'd0;    // [1:0] operation
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [0] recorded, [8:1] rec_type, [24:9] rec_offset,
                                     // [40:25] query_first, [56:41] query_count,
                                     // [57] walk_stopped

   smbios_type_index_walker_core #(
      .TABLE_ADDR_BITS(ADDR_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // stimulus and prediction stores
   walk_req_type pending_reqs[$];
   walk_rsp_type expected_rsps[$];
   int           queued_items = 0;
   int           mismatches = 0;
   bit           idle_on = 1'b1;

   // predicted walker state
   logic [7:0]     end_marker_q;
   walk_phase_type walk_phase;
   logic [7:0]     hdr_pos;
   logic [7:0]     fmt_len;
   logic [7:0]     cur_type;
   bit             last_zero;
   int unsigned    walk_offset;
   logic [15:0]    cur_start;
   bit             walk_done;
   logic [15:0]    first_off[256];
   logic [15:0]    type_cnt[256];

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic void clear_walk();
      walk_phase  = WALK_HEADER;
      hdr_pos     = 8'd0;
      fmt_len     = 8'd0;
      cur_type    = 8'd0;
      last_zero   = 1'b0;
      walk_offset = 0;
      cur_start   = 16'd0;
      walk_done   = 1'b0;
      for (int t = 0; t < 256; t++) begin
         first_off[t] = 16'd0;
         type_cnt[t]  = 16'd0;
      end
   endfunction

   // one table byte through the parser, returns 1 when a structure is counted
   function automatic bit parse_table_byte(input logic [7:0] b);
      bit counted;
      counted = 1'b0;
      case (walk_phase)
         WALK_HEADER: begin
            if (hdr_pos == 8'd0) begin
               cur_type  = b;
               cur_start = walk_offset[15:0];
            end else if (hdr_pos == 8'd1) begin
               fmt_len = b;
            end
            if (hdr_pos < stiw_pkg::HDR_SIZE) begin
               hdr_pos++;
            end else begin
               // fifth byte: end marker or short length ends the walk uncounted
               if (cur_type == end_marker_q || fmt_len < stiw_pkg::HDR_SIZE) begin
                  walk_done = 1'b1;
                  return 1'b0;
               end
               if (type_cnt[cur_type] == 16'd0) first_off[cur_type] = cur_start;
               if (type_cnt[cur_type] != stiw_pkg::COUNT_MAX) type_cnt[cur_type]++;
               counted = 1'b1;
               if (fmt_len == stiw_pkg::HDR_SIZE) begin
                  // no formatted bytes beyond the header: this byte opens the strings
                  walk_phase = WALK_STRINGS;
                  last_zero  = (b == 8'd0);
               end else begin
                  walk_phase = WALK_FORMATTED;
                  hdr_pos++;
               end
            end
         end
         WALK_FORMATTED: begin
            if (hdr_pos >= fmt_len) begin
               walk_phase = WALK_STRINGS;
               last_zero  = (b == 8'd0);
            end else begin
               hdr_pos++;
            end
            if (walk_phase == WALK_FORMATTED && hdr_pos >= fmt_len) hdr_pos = fmt_len;
         end
         default: begin
            // double zero closes the string set
            if (b == 8'd0 && last_zero) begin
               walk_phase = WALK_HEADER;
               hdr_pos    = 8'd0;
               last_zero  = 1'b0;
            end else begin
               last_zero = (b == 8'd0);
            end
         end
      endcase
      return counted;
   endfunction

   function automatic void predict_walk(input walk_req_type r);
      walk_rsp_type e;
      bit           counted;
      e       = '{default: '0};
      counted = 1'b0;
      case (r.op)
         stiw_pkg::OP_BYTE: begin
            if (!walk_done) begin
               if (walk_offset >= WALK_CAPACITY) begin
                  walk_done = 1'b1;   // past capacity: byte dropped
               end else begin
                  counted = parse_table_byte(r.data_byte);
                  if (!walk_done) walk_offset++;
                  if (r.is_last) walk_done = 1'b1;
               end
            end
            if (counted) begin
               e.recorded   = 1'b1;
               e.rec_type   = cur_type;
               e.rec_offset = cur_start;
            end
         end
         stiw_pkg::OP_QUERY: begin
            e.query_first = first_off[r.query_type];
            e.query_count = type_cnt[r.query_type];
         end
         stiw_pkg::OP_CLEAR: clear_walk();
         default: ;
      endcase
      e.walk_stopped = walk_done;
      expected_rsps.push_back(e);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------------
   function automatic void push_item(input logic [1:0] op, input logic [7:0] b,
                                     input logic lst, input logic [7:0] qt);
      walk_req_type r;
      r.op         = op;
      r.data_byte  = b;
      r.is_last    = lst;
      r.query_type = qt;
      pending_reqs.push_back(r);
      queued_items++;
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic lst = 1'b0);
      push_item(stiw_pkg::OP_BYTE, b, lst, 8'($urandom_range(0, 255)));
   endfunction

   function automatic void push_query(input logic [7:0] qt);
      push_item(stiw_pkg::OP_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), qt);
   endfunction

   // mostly a few common types so counts climb, never the end marker
   function automatic logic [7:0] pick_type();
      logic [7:0] t;
      t = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      if (t == end_marker_q) t = t + 8'd1;
      return t;
   endfunction

   function automatic logic [7:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 8'($urandom_range(4, 8));
      if (r < 95) return 8'($urandom_range(9, 40));
      return 8'($urandom_range(41, 255));
   endfunction

   // header, formatted area, then 0..3 strings and the closing zero
   function automatic int queue_struct(input logic [7:0] stype, input logic [7:0] slen,
                                       input bit mark_last);
      logic [7:0] bytes[$];
      int         nstr;
      bytes.push_back(stype);
      bytes.push_back(slen);
      bytes.push_back(8'($urandom_range(0, 255)));
      bytes.push_back(8'($urandom_range(0, 255)));
      for (int i = 4; i < slen; i++) bytes.push_back(8'($urandom_range(0, 255)));
      nstr = $urandom_range(0, 3);
      for (int s = 0; s < nstr; s++) begin
         repeat ($urandom_range(1, 6)) bytes.push_back(8'($urandom_range(1, 255)));
         bytes.push_back(8'd0);
      end
      if (nstr == 0) bytes.push_back(8'd0);
      bytes.push_back(8'd0);
      foreach (bytes[i]) push_byte(bytes[i], mark_last && (i == bytes.size() - 1));
      return bytes.size();
   endfunction

   // one table walk: mostly well formed, with queries, noise and broken endings
   function automatic void queue_index_run();
      int nstructs;
      int nb;
      if ($urandom_range(0, 99) < 85)
         push_item(stiw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)));
      nstructs = $urandom_range(1, 12);
      repeat (nstructs) begin
         case ($urandom_range(0, 19))
            0, 1: push_query(8'($urandom_range(0, 255)));
            2, 3: push_query(8'($urandom_range(0, 8)));
            4:    push_item(OP_NOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)));
            5:    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            default: ;
         endcase
         nb = queue_struct(pick_type(), pick_len(), 1'b0);
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: nb = queue_struct(end_marker_q, 8'($urandom_range(0, 255)), 1'b0);
         4, 5:       nb = queue_struct(pick_type(), pick_len(), 1'b1);
         6:          nb = queue_struct(pick_type(), 8'($urandom_range(0, 3)), 1'b0);
         7:          push_item(stiw_pkg::OP_CLEAR, 8'd0, 1'b0, 8'd0);
         default: ;
      endcase
      repeat ($urandom_range(1, 3)) push_query(8'($urandom_range(0, 8)));
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   walk_req_type drv_item;
   int           send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_walk(drv_item);
            send_gap = idle_on ? $urandom_range(0, 14) : 0;
         end
         // slot is free when nothing is offered or the offer just went through
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               drv_item = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {drv_item.query_type, drv_item.data_byte};
               req_tuser  <= drv_item.op;
               req_tlast  <= drv_item.is_last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response monitor
   // ------------------------------------------------------------------------
   int rsp_count = 0;
   int rsp_stall = 0;

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] seen);
      if (seen !== want) begin
         if (mismatches < REPORT_CAP)
            $display("%0t: response %0d %s mismatch, expected %0h, actual %0h",
                     $time, rsp_count, name, want, seen);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      walk_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               if (mismatches < REPORT_CAP)
                  $display("%0t: unexpected response, expected none, actual %h",
                           $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("recorded",     want.recorded,     rsp_tdata[0]);
               check_field("rec_type",     want.rec_type,     rsp_tdata[8:1]);
               check_field("rec_offset",   want.rec_offset,   rsp_tdata[24:9]);
               check_field("query_first",  want.query_first,  rsp_tdata[40:25]);
               check_field("query_count",  want.query_count,  rsp_tdata[56:41]);
               check_field("walk_stopped", want.walk_stopped, rsp_tdata[57]);
            end
            rsp_count++;
            // one long hold-off so the block backs up and drops req_tready
            rsp_stall = (rsp_count == HOLD_AT) ? HOLD_CYCLES
                                               : (idle_on ? $urandom_range(0, 14) : 0);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequencing
   // ------------------------------------------------------------------------
   // idle means nothing queued, nothing offered and nothing outstanding
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_end_marker(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      end_marker_q = v;
      @(negedge clock);
   endtask

   initial begin
      int target;
      end_marker_q = 8'd127;
      clear_walk();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty index, min and max types, short length, end marker,
      // last byte, bytes after stop, unused operation
      push_query(8'h00);
      push_byte(8'h00); push_byte(8'h04); push_byte(8'hFF); push_byte(8'hFF);
      push_byte(8'h00); push_byte(8'h00);
      push_byte(8'hFF); push_byte(8'h05); push_byte(8'h00); push_byte(8'h00);
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'h00);
      push_item(stiw_pkg::OP_QUERY, 8'h00, 1'b1, 8'hFF);
      push_item(OP_NOP, 8'hFF, 1'b1, 8'hFF);
      push_byte(8'h01); push_byte(8'h03); push_byte(8'h34); push_byte(8'h12);
      push_byte(8'h00);
      push_byte(8'h00);
      push_query(8'h01);
      push_item(stiw_pkg::OP_CLEAR, 8'hFF, 1'b1, 8'hFF);
      push_byte(8'h7F); push_byte(8'h04); push_byte(8'h00); push_byte(8'h00);
      push_byte(8'h00);
      push_item(stiw_pkg::OP_CLEAR, 8'h00, 1'b0, 8'h00);
      push_byte(8'h10, 1'b1);
      push_query(8'h10);
      wait_drained();

      // random tables under extreme and random end marker settings
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       write_end_marker(8'h00);
            1:       write_end_marker(8'hFF);
            default: write_end_marker(8'($urandom_range(0, 255)));
         endcase
         idle_on = (p != 2);
         target  = queued_items + RUN_ITEMS;
         while (queued_items < target) queue_index_run();
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, several times beyond the slowest correct run
   initial begin
      #500000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
src/stiw_pkg.sv
src/stiw_ram.sv
src/stiw_front.sv
src/stiw_queue.sv
src/stiw_back.sv
src/smbios_type_index_walker_core.sv
test/tb_smbios_type_index_walker_core.sv
